>>> rtl/core/sbp_pkg.sv
// ---------------------------------------------------------------------------
// Spike bias plasticity package
// Item types, fixed-point constants and the exponent polynomial table.
// ---------------------------------------------------------------------------
`default_nettype none

package sbp_pkg;

    localparam int unsigned FRAC_BITS = 16;
    localparam logic [31:0] Q_ONE     = 32'(1) << FRAC_BITS;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        event_time;
        logic signed [31:0] load_value;
    } t_sbp_in;

    typedef struct packed {
        logic signed [31:0] bias_out;
        logic               active_out;
    } t_sbp_out;

    // Horner coefficients, highest order used first. Entry zero is the
    // constant term 1.0 in Q30 that closes the polynomial.
    function automatic logic [31:0] horner_coef(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0:    c = 32'd1073741824;
            3'd1:    c = 32'd744261118;
            3'd2:    c = 32'd257941248;
            3'd3:    c = 32'd59597083;
            3'd4:    c = 32'd10327388;
            default: c = 32'd1431680;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/spike_bias_plasticity_update_top.sv
// ---------------------------------------------------------------------------
// Spike bias plasticity update, top level
// Event-driven bias learning for one neuron with a shared multiplier.
// ---------------------------------------------------------------------------
// Usage: events arrive as items on the input channel (i_in_valid /
// o_in_ready) and every event returns exactly one item on the output
// channel (o_out_valid / i_out_ready) holding the bias and active flag.
// Learning parameters are written over the APB port, and the user must
// write them only while the block is idle; the block does not enforce
// this. pready is always high and reads return the register values.
// Control events (toggle, activate, load, unused codes) and learning
// events while inactive show their result in the cycle after acceptance.
// A learning event runs a sequencer over one 34x34 signed multiplier:
// each exponent takes one product for the base-2 conversion and five
// for the polynomial, and a decay-only event skips the potentiation
// product. One item is in work at a time, so o_in_ready is low until
// the result has been taken, and the next item can be accepted in the
// cycle after that. A stalled receiver holds the result in the output
// register and the block takes no new item. Reset clears the bias, the
// last update time and the active flag, and loads every configuration
// register with its reset value.
// ---------------------------------------------------------------------------
`default_nettype none

module spike_bias_plasticity_update_top
    import sbp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_sbp_in  i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_sbp_out      o_out_item,
    input  wire logic     psel,
    input  wire logic     penable,
    input  wire logic     pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam logic [2:0] REG_LEARN_RATE  = 3'd0;
    localparam logic [2:0] REG_BIAS_GAIN   = 3'd1;
    localparam logic [2:0] REG_BIAS_OFFSET = 3'd2;
    localparam logic [2:0] REG_SPIKE_GAIN  = 3'd3;
    localparam logic [2:0] REG_MAX_STEP    = 3'd4;
    localparam logic [2:0] REG_UPPER_CLAMP = 3'd5;
    localparam logic [2:0] REG_LOWER_CLAMP = 3'd6;
    localparam logic [2:0] REG_HESSIAN     = 3'd7;

    localparam logic [2:0] OP_SPIKE    = 3'd0;
    localparam logic [2:0] OP_DECAY    = 3'd1;
    localparam logic [2:0] OP_TOGGLE   = 3'd2;
    localparam logic [2:0] OP_ACTIVATE = 3'd3;
    localparam logic [2:0] OP_LOAD     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_GB, S_EXP_Y, S_EXP_H, S_EXP_F, S_LM, S_T, S_DEC, S_POT,
        S_FIN, S_OUT
    } t_state;

    typedef enum logic {
        RET_M, RET_EB
    } t_ret;

    // Configuration registers
    logic [30:0]        r_learn_rate;
    logic signed [31:0] r_bias_gain;
    logic signed [31:0] r_bias_offset;
    logic [30:0]        r_spike_gain;
    logic [30:0]        r_max_step;
    logic signed [31:0] r_upper_clamp;
    logic signed [31:0] r_lower_clamp;
    logic               r_hessian;

    // Neuron state and sequencer
    t_state             r_state;
    t_ret               r_ret;
    logic               r_wait;
    logic signed [31:0] r_bias;
    logic [31:0]        r_last;
    logic               r_active;
    logic [31:0]        r_now;
    logic               r_spike;
    logic [2:0]         r_cnt;

    // Shared multiplier and working values
    logic signed [33:0] r_ma;
    logic signed [33:0] r_mb;
    logic signed [67:0] r_prod;
    logic signed [31:0] r_b;
    logic signed [21:0] r_k;
    logic [29:0]        r_u;
    logic [31:0]        r_p;
    logic [31:0]        r_lm;
    logic [30:0]        r_dec;
    logic [30:0]        r_pot;

    logic               w_cfg_wr;
    logic               w_in_acc;
    logic signed [52:0] w_b_sum;
    logic signed [31:0] w_b_sat;
    logic [31:0]        w_qsat;
    logic [31:0]        w_h_p;
    logic signed [22:0] w_sh;
    logic [22:0]        w_rs;
    logic [31:0]        w_shifted;
    logic [31:0]        w_e;
    logic signed [33:0] w_nb;
    logic signed [31:0] w_nb_clamped;
    logic [31:0]        w_elapsed;
    logic [29:0]        w_u;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_item.bias_out   = r_bias;
    assign o_out_item.active_out = r_active;

    always_comb begin
        case (paddr[4:2])
            REG_LEARN_RATE:  prdata = {1'b0, r_learn_rate};
            REG_BIAS_GAIN:   prdata = r_bias_gain;
            REG_BIAS_OFFSET: prdata = r_bias_offset;
            REG_SPIKE_GAIN:  prdata = {1'b0, r_spike_gain};
            REG_MAX_STEP:    prdata = {1'b0, r_max_step};
            REG_UPPER_CLAMP: prdata = r_upper_clamp;
            REG_LOWER_CLAMP: prdata = r_lower_clamp;
            REG_HESSIAN:     prdata = {31'd0, r_hessian};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate  <= 31'd0;
            r_bias_gain   <= Q_ONE;
            r_bias_offset <= 32'sd0;
            r_spike_gain  <= Q_ONE[30:0];
            r_max_step    <= Q_ONE[30:0];
            r_upper_clamp <= 32'sh7FFF_FFFF;
            r_lower_clamp <= 32'sh8000_0000;
            r_hessian     <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_LEARN_RATE:  r_learn_rate  <= pwdata[30:0];
                REG_BIAS_GAIN:   r_bias_gain   <= pwdata;
                REG_BIAS_OFFSET: r_bias_offset <= pwdata;
                REG_SPIKE_GAIN:  r_spike_gain  <= pwdata[30:0];
                REG_MAX_STEP:    r_max_step    <= pwdata[30:0];
                REG_UPPER_CLAMP: r_upper_clamp <= pwdata;
                REG_LOWER_CLAMP: r_lower_clamp <= pwdata;
                REG_HESSIAN:     r_hessian     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // b = floor(gain * bias) + offset, saturated to 32 bits
        w_b_sum = {r_prod[67], r_prod[67:16]} + 53'(r_bias_offset);
        if (w_b_sum > 53'sh7FFF_FFFF) begin
            w_b_sat = 32'sh7FFF_FFFF;
        end else if (w_b_sum < -53'sh8000_0000) begin
            w_b_sat = 32'sh8000_0000;
        end else begin
            w_b_sat = w_b_sum[31:0];
        end

        // Unsigned Q product, floored, saturated at all ones
        w_qsat = (|r_prod[67:FRAC_BITS + 32]) ? 32'hFFFF_FFFF
                                              : r_prod[FRAC_BITS + 31:FRAC_BITS];

        w_u   = {r_prod[45:30], 14'd0};
        w_h_p = horner_coef(r_cnt) + r_prod[61:30];

        // Scale the polynomial by 2^k into Q16.16
        w_sh      = {r_k[21], r_k} - 23'sd14;
        w_rs      = 23'(-w_sh);
        w_shifted = r_p >> w_rs[4:0];
        if (w_sh > 23'sd0) begin
            w_e = 32'h7FFF_FFFF;
        end else if (|w_rs[22:5]) begin
            w_e = 32'd0;
        end else if (w_shifted[31]) begin
            w_e = 32'h7FFF_FFFF;
        end else begin
            w_e = w_shifted;
        end

        w_elapsed = r_now - r_last;

        // The new bias can leave the 32-bit range, so both bounds are
        // compared at full width before it is narrowed.
        w_nb = 34'(r_bias) - {3'd0, r_dec} + {3'd0, r_pot};
        if (w_nb > 34'(r_upper_clamp)) begin
            w_nb_clamped = r_upper_clamp;
        end else if (w_nb < 34'(r_lower_clamp)) begin
            w_nb_clamped = r_lower_clamp;
        end else begin
            w_nb_clamped = w_nb[31:0];
        end
        if (w_nb_clamped < r_lower_clamp) begin
            w_nb_clamped = r_lower_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_bias   <= 32'sd0;
            r_last   <= 32'd0;
            r_active <= 1'b0;
            r_ret    <= RET_M;
        end else if (r_wait) begin
            // The product issued in the previous cycle lands in r_prod now.
            r_wait <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_now   <= i_in_item.event_time;
                        r_spike <= (i_in_item.op == OP_SPIKE);
                        r_state <= S_OUT;
                        case (i_in_item.op)
                            OP_SPIKE, OP_DECAY: begin
                                if (r_active) begin
                                    r_ma    <= 34'(r_bias_gain);
                                    r_mb    <= 34'(r_bias);
                                    r_wait  <= 1'b1;
                                    r_state <= S_GB;
                                end
                            end
                            OP_TOGGLE: begin
                                r_active <= !r_active;
                                r_last   <= i_in_item.event_time;
                            end
                            OP_ACTIVATE: begin
                                if (!r_active) begin
                                    r_last <= i_in_item.event_time;
                                end
                                r_active <= 1'b1;
                            end
                            OP_LOAD: begin
                                r_bias <= i_in_item.load_value;
                            end
                            default: ;
                        endcase
                    end
                end
                S_GB: begin
                    r_b    <= w_b_sat;
                    r_wait <= 1'b1;
                    if (r_hessian) begin
                        r_ma    <= -34'(w_b_sat);
                        r_mb    <= {3'd0, LOG2E_Q30};
                        r_ret   <= RET_M;
                        r_state <= S_EXP_Y;
                    end else begin
                        r_ma    <= {3'd0, r_learn_rate};
                        r_mb    <= {2'd0, Q_ONE};
                        r_state <= S_LM;
                    end
                end
                S_EXP_Y: begin
                    r_k     <= r_prod[67:46];
                    r_u     <= w_u;
                    r_ma    <= {2'd0, horner_coef(3'd5)};
                    r_mb    <= {4'd0, w_u};
                    r_cnt   <= 3'd4;
                    r_wait  <= 1'b1;
                    r_state <= S_EXP_H;
                end
                S_EXP_H: begin
                    if (r_cnt != 3'd0) begin
                        r_ma   <= {2'd0, w_h_p};
                        r_mb   <= {4'd0, r_u};
                        r_cnt  <= r_cnt - 3'd1;
                        r_wait <= 1'b1;
                    end else begin
                        r_p     <= w_h_p;
                        r_state <= S_EXP_F;
                    end
                end
                S_EXP_F: begin
                    r_wait <= 1'b1;
                    if (r_ret == RET_M) begin
                        r_ma    <= {3'd0, r_learn_rate};
                        r_mb    <= {2'd0, w_e};
                        r_state <= S_LM;
                    end else begin
                        r_ma    <= {2'd0, r_lm};
                        r_mb    <= {2'd0, w_e};
                        r_state <= S_T;
                    end
                end
                S_LM: begin
                    r_lm    <= w_qsat;
                    r_ma    <= 34'(r_b);
                    r_mb    <= {3'd0, LOG2E_Q30};
                    r_ret   <= RET_EB;
                    r_wait  <= 1'b1;
                    r_state <= S_EXP_Y;
                end
                S_T: begin
                    r_ma    <= {2'd0, w_qsat};
                    r_mb    <= {2'd0, w_elapsed};
                    r_wait  <= 1'b1;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_dec <= (w_qsat > {1'b0, r_max_step}) ? r_max_step : w_qsat[30:0];
                    if (r_spike) begin
                        r_ma    <= {2'd0, r_lm};
                        r_mb    <= {3'd0, r_spike_gain};
                        r_wait  <= 1'b1;
                        r_state <= S_POT;
                    end else begin
                        r_pot   <= 31'd0;
                        r_state <= S_FIN;
                    end
                end
                S_POT: begin
                    r_pot <= (w_qsat > {1'b0, r_max_step}) ? r_max_step : w_qsat[30:0];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_bias  <= w_nb_clamped;
                    r_last  <= r_now;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sbp_checker.sv
// ---------------------------------------------------------------------------
// Spike bias plasticity port checker
// Watches the top level's ports for handshake and sequencing slips.
// ---------------------------------------------------------------------------
`default_nettype none

module sbp_checker
    import sbp_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_ready,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_sbp_out o_out_item,
    input wire logic     pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result item changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("new item offered while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an item was accepted");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port inserted a wait state");

endmodule

bind spike_bias_plasticity_update_top sbp_checker u_sbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .pready      (pready)
);

`default_nettype wire

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// Spike bias plasticity testbench
// Drives event items and APB register writes into the bias learning block
// and checks the bias and active flag of every result item against a
// fixed-point predictor that also tracks the last update time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import sbp_pkg::*;

    localparam logic [2:0] OP_SPIKE    = 3'd0;
    localparam logic [2:0] OP_DECAY    = 3'd1;
    localparam logic [2:0] OP_TOGGLE   = 3'd2;
    localparam logic [2:0] OP_ACTIVATE = 3'd3;
    localparam logic [2:0] OP_LOAD     = 3'd4;

    localparam logic [4:0] REG_LEARN_RATE  = 5'd0;
    localparam logic [4:0] REG_BIAS_GAIN   = 5'd4;
    localparam logic [4:0] REG_BIAS_OFFSET = 5'd8;
    localparam logic [4:0] REG_SPIKE_GAIN  = 5'd12;
    localparam logic [4:0] REG_MAX_STEP    = 5'd16;
    localparam logic [4:0] REG_UPPER       = 5'd20;
    localparam logic [4:0] REG_LOWER       = 5'd24;
    localparam logic [4:0] REG_HESSIAN     = 5'd28;

    localparam longint CYCLE_LIMIT = 2000000;

    // -----------------------------------------------------------------------
    // Bias learning predictor and store of expected result items
    // -----------------------------------------------------------------------
    class bias_scoreboard;
        longint unsigned eta, tau, cap;
        longint gain, offset, upper, lower;
        bit hess;
        longint bias;
        longint unsigned t_last;
        bit active;
        t_sbp_out pending[$];
        int errors;
        int seen;

        function new();
            eta = 0; gain = 65536; offset = 0; tau = 65536; cap = 65536;
            upper = 64'sd2147483647; lower = -64'sd2147483648; hess = 0;
            bias = 0; t_last = 0; active = 0; errors = 0; seen = 0;
        endfunction

        function void write_reg(logic [4:0] addr, logic [31:0] v);
            case (addr)
                REG_LEARN_RATE:  eta = v[30:0];
                REG_BIAS_GAIN:   gain = longint'($signed(v));
                REG_BIAS_OFFSET: offset = longint'($signed(v));
                REG_SPIKE_GAIN:  tau = v[30:0];
                REG_MAX_STEP:    cap = v[30:0];
                REG_UPPER:       upper = longint'($signed(v));
                REG_LOWER:       lower = longint'($signed(v));
                REG_HESSIAN:     hess = v[0];
                default: ;
            endcase
        endfunction

        function longint floor_shr(longint x, int s);
            return x >>> s;
        endfunction

        function longint unsigned umul_q(longint unsigned a, longint unsigned b);
            logic [127:0] p;
            p = (128'(a) * 128'(b)) >> FRAC_BITS;
            return (p > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : p[63:0];
        endfunction

        function longint unsigned exp_q(longint x);
            longint unsigned coef[5] = '{744261118, 257941248, 59597083,
                                         10327388, 1431680};
            longint y, k, sh;
            longint unsigned u, p;
            y = floor_shr(x * 1549082005, 30);
            k = floor_shr(y, FRAC_BITS);
            u = (longint'(y) & 64'hFFFF) << (30 - FRAC_BITS);
            p = coef[4];
            for (int i = 3; i >= 0; i--) p = coef[i] + ((p * u) >> 30);
            p = (64'd1 << 30) + ((p * u) >> 30);
            sh = k + FRAC_BITS - 30;
            if (sh > 0) return 64'h7FFF_FFFF;
            if (-sh >= 63) return 0;
            p = p >> (-sh);
            return (p > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : p;
        endfunction

        function void learn(longint unsigned now, bit with_spike);
            longint b, nb;
            longint unsigned m, decay, pot, dt;
            b = floor_shr(gain * bias, FRAC_BITS) + offset;
            if (b > 64'sd2147483647) b = 64'sd2147483647;
            if (b < -64'sd2147483648) b = -64'sd2147483648;
            m = hess ? exp_q(-b) : 64'd65536;
            dt = (now - t_last) & 64'hFFFF_FFFF;
            decay = umul_q(umul_q(umul_q(eta, m), exp_q(b)), dt);
            if (decay > cap) decay = cap;
            pot = 0;
            if (with_spike) begin
                pot = umul_q(umul_q(eta, m), tau);
                if (pot > cap) pot = cap;
            end
            nb = bias - longint'(decay) + longint'(pot);
            if (nb > upper) nb = upper;
            if (nb < lower) nb = lower;
            bias = nb;
            t_last = now;
        endfunction

        function void note_event(t_sbp_in it);
            t_sbp_out r;
            case (it.op)
                OP_SPIKE, OP_DECAY: if (active) learn(it.event_time, it.op == OP_SPIKE);
                OP_TOGGLE: begin
                    active = !active;
                    t_last = it.event_time;
                end
                OP_ACTIVATE: begin
                    if (!active) t_last = it.event_time;
                    active = 1;
                end
                OP_LOAD: bias = longint'(it.load_value);
                default: ;
            endcase
            r.bias_out = bias[31:0];
            r.active_out = active;
            pending.push_back(r);
        endfunction

        function void check_result(t_sbp_out got);
            t_sbp_out want;
            seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result bias=%h active=%0b", $time,
                         got.bias_out, got.active_out);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.bias_out !== want.bias_out) begin
                $display("%0t: bias mismatch expected %h actual %h", $time,
                         want.bias_out, got.bias_out);
                errors++;
            end
            if (got.active_out !== want.active_out) begin
                $display("%0t: active mismatch expected %0b actual %0b", $time,
                         want.active_out, got.active_out);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    t_sbp_in i_in_item = '0;
    logic o_out_valid;
    logic i_out_ready = 0;
    t_sbp_out o_out_item;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    bias_scoreboard sb = new();
    longint cycles = 0;
    int sent = 0;
    logic [31:0] clock_now = 0;

    always #5 i_clk = ~i_clk;

    spike_bias_plasticity_update_top dut (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: score accepted items and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
        if (!i_rst_n) i_out_ready <= 0;
        else i_out_ready <= ($urandom_range(0, 99) < 15) ? 1'b0 : 1'b1;
    end

    task automatic write_reg(logic [4:0] addr, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.write_reg(addr, v);
    endtask

    task automatic send_event(logic [2:0] op, logic [31:0] t, logic [31:0] lv);
        t_sbp_in it;
        int g;
        g = gap_len();
        // The block is busy in the cycle after an accepted item, so valid
        // is always dropped before the next item is offered.
        repeat (g + 1) @(posedge i_clk);
        it.op = op; it.event_time = t; it.load_value = lv;
        i_in_valid <= 1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_event(it);
        sent++;
        i_in_valid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Small forward steps of time keep decay terms in range most of the time.
    function automatic logic [31:0] next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) clock_now = clock_now + $urandom_range(0, 32'h0004_0000);
        else if (r < 92) clock_now = clock_now + $urandom();
        else clock_now = clock_now - $urandom_range(0, 32'h0010_0000);
        return clock_now;
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return OP_SPIKE;
        if (r < 70) return OP_DECAY;
        if (r < 78) return OP_TOGGLE;
        if (r < 86) return OP_ACTIVATE;
        if (r < 96) return OP_LOAD;
        return 3'($urandom_range(5, 7));
    endfunction

    task automatic random_config(bit hessian);
        write_reg(REG_LEARN_RATE, $urandom_range(0, 99) < 10 ? 32'h7FFF_FFFF :
                  $urandom_range(0, 32'h0002_0000));
        write_reg(REG_BIAS_GAIN, $urandom_range(0, 9) == 0 ? $urandom() :
                  32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000));
        write_reg(REG_BIAS_OFFSET, $urandom_range(0, 9) == 0 ? $urandom() :
                  32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000));
        write_reg(REG_SPIKE_GAIN, $urandom_range(0, 32'h0004_0000));
        write_reg(REG_MAX_STEP, $urandom_range(0, 9) == 0 ? 32'h7FFF_FFFF :
                  $urandom_range(0, 32'h0004_0000));
        write_reg(REG_UPPER, $urandom_range(0, 4) == 0 ? 32'h7FFF_FFFF :
                  $urandom_range(0, 32'h0010_0000));
        write_reg(REG_LOWER, $urandom_range(0, 4) == 0 ? 32'h8000_0000 :
                  -$urandom_range(0, 32'h0010_0000));
        write_reg(REG_HESSIAN, {31'd0, hessian});
    endtask

    initial begin
        logic [2:0] op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part at reset settings: inactive learning, then learning.
        send_event(OP_SPIKE, 32'h0001_0000, 0);
        send_event(OP_LOAD, 0, 32'h8000_0000);
        send_event(OP_LOAD, 0, 32'h7FFF_FFFF);
        send_event(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(3'd7, 0, 0);
        send_event(OP_ACTIVATE, 32'h0000_1000, 0);
        send_event(OP_ACTIVATE, 32'h0000_2000, 0);
        send_event(OP_LOAD, 0, 0);
        drain();
        write_reg(REG_LEARN_RATE, 32'h0000_4000);
        send_event(OP_SPIKE, 32'h0000_8000, 0);
        send_event(OP_DECAY, 32'h0001_0000, 0);
        // Time going back wraps to a huge elapsed time.
        send_event(OP_DECAY, 32'h0000_0100, 0);
        send_event(OP_SPIKE, 32'hFFFF_FFFF, 0);
        send_event(OP_TOGGLE, 32'h0000_0000, 0);
        send_event(OP_SPIKE, 32'h0004_0000, 0);
        send_event(OP_TOGGLE, 32'h0000_0010, 0);
        drain();
        // Crossed clamps: the lower bound wins.
        write_reg(REG_UPPER, 32'hFFFF_0000);
        write_reg(REG_LOWER, 32'h0002_0000);
        write_reg(REG_HESSIAN, 1);
        send_event(OP_SPIKE, 32'h0000_0020, 0);
        send_event(OP_LOAD, 0, 32'h8000_0000);
        send_event(OP_SPIKE, 32'h0001_0020, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            random_config(ph[0]);
            if (ph == 7) begin
                write_reg(REG_BIAS_GAIN, 32'h8000_0000);
                write_reg(REG_BIAS_OFFSET, 32'h7FFF_FFFF);
                write_reg(REG_SPIKE_GAIN, 32'h7FFF_FFFF);
            end
            for (int n = 0; n < 250; n++) begin
                op = pick_op();
                send_event(op, next_time(),
                           $urandom_range(0, 3) == 0 ? $urandom() :
                           32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000));
            end
            drain();
        end

        $display("Sent %0d event items under the reset settings, two directed settings",
                 sent);
        $display("and eight random ones; %0d results scored.", sb.seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/core/sbp_pkg.sv
rtl/core/spike_bias_plasticity_update_top.sv
rtl/core/sbp_checker.sv
dv/tb_top.sv
